// ----- rtl/ilist_pkg.sv -----
package ilist_pkg;

  // Command codes
  localparam logic [2:0] CMD_READ     = 3'd0;
  localparam logic [2:0] CMD_INS_HEAD = 3'd1;
  localparam logic [2:0] CMD_INS_TAIL = 3'd2;
  localparam logic [2:0] CMD_INS_POS  = 3'd3;
  localparam logic [2:0] CMD_DELETE   = 3'd4;

  // Status codes
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam int VALUE_W = 32;
  localparam int POS_W   = 6;
  localparam int CMD_W   = 3;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 6;

  // Wide enough for any position or count up to the largest supported depth.
  localparam int OP_POS_W = 11;

  localparam logic signed [VALUE_W-1:0] NOT_READ = -32'sd1;

  typedef struct packed {
    logic                ins;
    logic                del;
    logic [OP_POS_W-1:0] pos;
  } list_op_t;

endpackage

// ----- rtl/ilist_array.sv -----
module ilist_array import ilist_pkg::*; #(
  parameter int DEPTH = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  list_op_t                            op,
  input  logic signed [VALUE_W-1:0]           wr_value,
  input  logic [$clog2(DEPTH)-1:0]            rd_index,
  output logic signed [VALUE_W-1:0]           rd_value,
  output logic [$clog2(DEPTH+1)-1:0]          count
);

  localparam int CW = $clog2(DEPTH + 1);

  logic signed [VALUE_W-1:0] ent [DEPTH];

  // Each slot picks from itself, its lower or its upper neighbour, or the new value.
  for (genvar i = 0; i < DEPTH; i++) begin : g_slot
    always_ff @(posedge clk) begin
      if (op.ins) begin
        if (OP_POS_W'(i) == op.pos) begin
          ent[i] <= wr_value;
        end else if (OP_POS_W'(i) > op.pos) begin
          if (i > 0) begin
            ent[i] <= ent[(i > 0) ? i - 1 : 0];
          end
        end
      end else if (op.del) begin
        if (OP_POS_W'(i) >= op.pos && i < DEPTH - 1) begin
          ent[i] <= ent[(i < DEPTH - 1) ? i + 1 : i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (op.ins) begin
      count <= count + CW'(1);
    end else if (op.del) begin
      count <= count - CW'(1);
    end
  end

  assign rd_value = ent[rd_index];

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count beyond depth");

  a_ins_grows: assert property (@(posedge clk) disable iff (rst)
    op.ins |=> count == $past(count) + CW'(1))
    else $error("insert did not add one entry");

  a_one_op: assert property (@(posedge clk) disable iff (rst)
    !(op.ins && op.del))
    else $error("insert and delete in the same cycle");

endmodule

// ----- rtl/indexed_list_insert_delete_core.sv -----
// Ordered list of up to DEPTH signed 32-bit words held in a register array
// that shifts in place. Each input word carries one command (read, insert at
// head, insert at tail, insert before a position, delete at a position) and
// yields exactly one output word with the value read, a status and the entry
// count after the command. A command passes through an input register and
// its result is then written to the output register, so the block takes
// one command every cycle while the output is not held back by m_tready.
// A command is applied to the list only as its result enters the output
// register.
module indexed_list_insert_delete_core import ilist_pkg::*; #(
  parameter int DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // command [2:0], position [8:3], item_value [40:9], zero fill [47:41]
  input  logic [47:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // read_value [31:0], status [33:32], entry_count [39:34]
  output logic [39:0] m_tdata
);

  localparam int IW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;

  logic                      in_valid;
  logic [CMD_W-1:0]          cmd;
  logic [POS_W-1:0]          pos;
  logic signed [VALUE_W-1:0] value;

  logic                      out_valid;
  logic signed [VALUE_W-1:0] out_value;
  logic [STAT_W-1:0]         out_status;
  logic [COUNT_W-1:0]        out_count;

  logic                      move;
  list_op_t                  op;
  logic signed [VALUE_W-1:0] rd_data;
  logic [CW-1:0]             count;
  logic [CMPW-1:0]           pos_ext;
  logic [CMPW-1:0]           cnt_ext;
  logic [CMPW-1:0]           ins_pos;
  logic [CMPW-1:0]           cnt_next;
  logic signed [VALUE_W-1:0] value_next;
  logic [STAT_W-1:0]         status_next;
  logic                      do_ins;
  logic                      do_del;

  assign move     = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || move;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      cmd   <= s_tdata[2:0];
      pos   <= s_tdata[8:3];
      value <= s_tdata[40:9];
    end
  end

  assign pos_ext = CMPW'(pos);
  assign cnt_ext = CMPW'(count);

  always_comb begin
    value_next  = NOT_READ;
    status_next = ST_RANGE;
    do_ins      = 1'b0;
    do_del      = 1'b0;
    ins_pos     = pos_ext;
    case (cmd)
      CMD_READ: begin
        if (pos_ext < cnt_ext) begin
          value_next  = rd_data;
          status_next = ST_DONE;
        end
      end
      CMD_INS_HEAD, CMD_INS_TAIL, CMD_INS_POS: begin
        if (cmd == CMD_INS_HEAD) begin
          ins_pos = '0;
        end else if (cmd == CMD_INS_TAIL) begin
          ins_pos = cnt_ext;
        end
        // The range check takes precedence over the full check.
        if (ins_pos > cnt_ext) begin
          status_next = ST_RANGE;
        end else if (cnt_ext == CMPW'(DEPTH)) begin
          status_next = ST_FULL;
        end else begin
          status_next = ST_DONE;
          do_ins      = 1'b1;
        end
      end
      CMD_DELETE: begin
        if (pos_ext < cnt_ext) begin
          status_next = ST_DONE;
          do_del      = 1'b1;
        end
      end
      default: begin
        status_next = ST_RANGE;
      end
    endcase
  end

  assign op.ins = move && do_ins;
  assign op.del = move && do_del;
  assign op.pos = OP_POS_W'(do_ins ? ins_pos : pos_ext);

  assign cnt_next = do_ins ? cnt_ext + CMPW'(1) : (do_del ? cnt_ext - CMPW'(1) : cnt_ext);

  ilist_array #(
    .DEPTH (DEPTH)
  ) u_array (
    .clk      (clk),
    .rst      (rst),
    .op       (op),
    .wr_value (value),
    .rd_index (pos_ext[IW-1:0]),
    .rd_value (rd_data),
    .count    (count)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (move) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_value  <= value_next;
      out_status <= status_next;
      out_count  <= cnt_next[COUNT_W-1:0];
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_count, out_status, out_value};

  a_read_only_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_value != NOT_READ |-> out_status == ST_DONE)
    else $error("value returned without a completed read");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status == ST_FULL |-> out_count == COUNT_W'(DEPTH))
    else $error("full status with a list that is not full");

  a_count_tracks: assert property (@(posedge clk) disable iff (rst)
    move |=> out_count == COUNT_W'(count))
    else $error("reported count differs from the list count");

endmodule
